>>> rtl/core/wpm_pkg.sv
// Shared types and constants of the word pattern matcher.
// Depends on nothing; every other file of the block imports it.
package wpm_pkg;

  // Pattern cells in the row and fixed field widths
  localparam int unsigned MaxPattern = 32;
  localparam int unsigned PatBytes   = 32;
  localparam int unsigned CharW      = 8;
  localparam int unsigned PosW       = 6;
  localparam int unsigned ModeW      = 2;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned CfgIdxW    = 3;

  localparam logic [PosW-1:0]  PosLimit = PosW'(63);
  // Effective length compare is one bit wider so MaxPattern up to 64 fits
  localparam logic [PosW:0]    MaxLen   = (PosW+1)'(MaxPattern);

  localparam logic [CharW-1:0] ChDot   = 8'h2E;
  localparam logic [CharW-1:0] ChSlash = 8'h2F;
  localparam logic [CharW-1:0] ChSpace = 8'h20;

  typedef enum logic [ModeW-1:0] {
    ModePlain  = 2'd0,
    ModeSlash  = 2'd1,
    ModeCrypto = 2'd2
  } match_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegMode   = 3'd0,
    RegLength = 3'd1,
    RegCharsA = 3'd2,
    RegCharsB = 3'd3,
    RegCharsC = 3'd4,
    RegCharsD = 3'd5
  } cfg_reg_e;

  // Control broadcast from the top level to every cell
  typedef struct packed {
    logic             advance;  // a present character is taken this cycle
    logic             clear;    // the word ends this cycle
    logic [ModeW-1:0] mode;
  } cell_ctrl_t;

endpackage

>>> rtl/core/wpm_if.sv
// Valid/ready channel interfaces for character requests and match results.
// Depends on wpm_pkg.
interface wpm_in_if;
  import wpm_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] word_char;
  logic             char_present;
  logic             end_of_word;

  modport source (output valid, output word_char, output char_present,
                  output end_of_word, input ready);
  modport sink   (input valid, input word_char, input char_present,
                  input end_of_word, output ready);
endinterface

interface wpm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink   (input valid, input matched, output ready);
endinterface

>>> rtl/core/word_pattern_matcher.sv
// Top level of the word pattern matcher: configuration, cell row, result register.
// Depends on wpm_pkg, wpm_if (wpm_in_if, wpm_out_if) and wpm_cell.
//
// Usage: words stream in on in_if, one character request per cycle if ready. Each
// request carries word_char, char_present (0 for an empty close) and
// end_of_word. On the request that ends a word, one result with the match
// bit is queued in an output register and shown on out_if the next cycle.
// Requests that do not end a word give no result.
// Throughput: one request per cycle while out_if is not stalled; the cell
// row (one cell per pattern position, compared in parallel) updates per request.
// A new request is taken while a result waits, as long as that result is
// taken in the same cycle (ready = output empty or being drained).
// When the receiver stalls, the result holds and input stops after it.
// Reset clears the mode, length and pattern to zero and the word state;
// no clearing pass is needed. Configuration is written through cfg_we_i, cfg_idx_i
// and cfg_data_i only while no word is in progress; only the user ensures that.
module word_pattern_matcher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  wpm_in_if.sink                        in_if,
  wpm_out_if.source                     out_if,
  input  logic                          cfg_we_i,
  input  logic [wpm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [wpm_pkg::CfgDataW-1:0]  cfg_data_i
);
  import wpm_pkg::*;

  // Configuration registers
  logic [ModeW-1:0]           mode_q;
  logic [PosW-1:0]            len_q;
  logic [PatBytes*CharW-1:0]  pat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      len_q  <= '0;
      pat_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegMode:   mode_q <= cfg_data_i[ModeW-1:0];
        RegLength: len_q  <= cfg_data_i[PosW-1:0];
        RegCharsA: pat_q[0*CfgDataW +: CfgDataW] <= cfg_data_i;
        RegCharsB: pat_q[1*CfgDataW +: CfgDataW] <= cfg_data_i;
        RegCharsC: pat_q[2*CfgDataW +: CfgDataW] <= cfg_data_i;
        RegCharsD: pat_q[3*CfgDataW +: CfgDataW] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective pattern length, capped at the row size
  logic [PosW:0] len_eff;
  assign len_eff = ({1'b0, len_q} > MaxLen) ? MaxLen : {1'b0, len_q};

  // Handshake
  logic       out_valid_q, out_matched_q;
  logic       in_acc;
  logic       advance, last;
  cell_ctrl_t ctrl;

  assign in_if.ready = ~out_valid_q | out_if.ready;
  assign in_acc      = in_if.valid & in_if.ready;
  assign advance     = in_acc & in_if.char_present;
  assign last        = in_acc & in_if.end_of_word;

  assign ctrl.advance = advance;
  assign ctrl.clear   = last;
  assign ctrl.mode    = mode_q;

  // Cell row
  logic [MaxPattern:0]         fill;
  logic [MaxPattern-1:0]       conflict, agree;
  logic [CharW-1:0]            sel_pat [MaxPattern];
  logic [CharW-1:0]            cur_pat;

  assign fill[0] = 1'b1;

  for (genvar j = 0; j < MaxPattern; j++) begin : g_cell
    logic [CharW-1:0] own_pat;
    if (j < PatBytes) begin : g_pat
      assign own_pat = pat_q[j*CharW +: CharW];
    end else begin : g_zero
      assign own_pat = '0;
    end

    wpm_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .own_pat_i    (own_pat),
      .cur_pat_i    (cur_pat),
      .word_char_i  (in_if.word_char),
      .prev_valid_i (fill[j]),
      .valid_o      (fill[j+1]),
      .conflict_o   (conflict[j]),
      .agree_o      (agree[j]),
      .sel_pat_o    (sel_pat[j])
    );
  end

  // Pattern character of the current position, one-hot select from the row
  always_comb begin
    cur_pat = '0;
    for (int j = 0; j < MaxPattern; j++) begin
      cur_pat = cur_pat | sel_pat[j];
    end
  end

  // Word state
  logic [PosW-1:0] pos_q, pos_d;
  logic            mism_q, mism_d;
  logic            char_bad;
  logic            beyond;

  assign beyond   = {1'b0, pos_q} >= len_eff;
  assign char_bad = (mode_q == ModeCrypto) ? (|conflict) : ~(|agree);

  always_comb begin
    pos_d  = pos_q;
    mism_d = mism_q;
    if (advance) begin
      if (beyond || char_bad) begin
        mism_d = 1'b1;
      end
      if (pos_q < PosLimit) begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      mism_q <= 1'b0;
    end else if (last) begin
      pos_q  <= '0;
      mism_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      mism_q <= mism_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (last) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (last) begin
      out_matched_q <= ~mism_d & ({1'b0, pos_d} == len_eff);
    end
  end

  assign out_if.valid   = out_valid_q;
  assign out_if.matched = out_matched_q;

endmodule

>>> rtl/core/wpm_cell.sv
// One pattern position of the matcher row: holds the word character seen there.
// Depends on wpm_pkg.
module wpm_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wpm_pkg::cell_ctrl_t         ctrl_i,
  input  logic [wpm_pkg::CharW-1:0]   own_pat_i,
  input  logic [wpm_pkg::CharW-1:0]   cur_pat_i,
  input  logic [wpm_pkg::CharW-1:0]   word_char_i,
  input  logic                        prev_valid_i,
  output logic                        valid_o,
  output logic                        conflict_o,
  output logic                        agree_o,
  output logic [wpm_pkg::CharW-1:0]   sel_pat_o
);
  import wpm_pkg::*;

  logic             valid_q, valid_d;
  logic [CharW-1:0] wc_q, wc_d;
  logic             tok;
  logic             agree;

  // This cell is the current position when its left neighbor is filled and it is not
  assign tok = prev_valid_i & ~valid_q;

  // Wildcard compare (with slash matching space in slash mode) of the incoming character
  always_comb begin
    agree = (own_pat_i == ChDot) || (own_pat_i == word_char_i);
    if ((ctrl_i.mode == ModeSlash) && (own_pat_i == ChSlash) && (word_char_i == ChSpace)) begin
      agree = 1'b1;
    end
  end

  assign agree_o   = tok & agree;
  assign sel_pat_o = tok ? own_pat_i : '0;

  // One-to-one check: same pattern char must pair with same word char, both ways
  assign conflict_o = valid_q & ((own_pat_i == cur_pat_i) != (wc_q == word_char_i));

  // Fill mark shifts in from the left neighbor on each character
  always_comb begin
    valid_d = valid_q;
    wc_d    = wc_q;
    if (ctrl_i.advance) begin
      valid_d = prev_valid_i;
      if (tok) begin
        wc_d = word_char_i;
      end
    end
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wc_q <= wc_d;
  end

  assign valid_o = valid_q;

endmodule
